// ----- design/tcw_pkg.sv -----
// Shared types, constants and command/status structs for the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing else.
package tcw_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int NCELLS = COLS * ROWS;

   localparam int COL_W     = $clog2(COLS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int ADDR_W    = $clog2(NCELLS);
   localparam int CELL_W    = 16;
   localparam int COLOR_W   = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h0A;

   localparam logic [COLOR_W-1:0] RESET_FG = 4'd10;
   localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR = 2'd1;

   localparam logic [1:0] REQ_PUT       = 2'd0;
   localparam logic [1:0] REQ_BACKSPACE = 2'd1;
   localparam logic [1:0] REQ_READ      = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [6:0] read_col;
      logic [4:0] read_row;
   } tcw_req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_offset;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } tcw_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_BLANK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FINISH
   } tcw_state_type;

   typedef enum logic [2:0] {
      AD_CURSOR,
      AD_CURSOR_PREV,
      AD_IDX,
      AD_IDX_NEXT_ROW,
      AD_READ
   } tcw_addr_sel_type;

   typedef enum logic [1:0] {
      WD_RESET,
      WD_CHAR,
      WD_SPACE,
      WD_RDATA
   } tcw_wdata_sel_type;

   typedef enum logic [2:0] {
      COL_HOLD,
      COL_ZERO,
      COL_INC,
      COL_DEC,
      COL_LAST,
      COL_SCAN_END
   } tcw_col_op_type;

   typedef enum logic [1:0] {
      ROW_HOLD,
      ROW_INC,
      ROW_DEC
   } tcw_row_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_INC,
      IDX_BLANK
   } tcw_idx_op_type;

   typedef struct packed {
      logic              latch_req;
      logic              hit_load;
      logic              mem_we;
      logic              mem_re;
      tcw_addr_sel_type  addr_sel;
      tcw_wdata_sel_type wdata_sel;
      tcw_col_op_type    col_op;
      tcw_row_op_type    row_op;
      tcw_idx_op_type    idx_op;
      logic              rsp_load;
   } tcw_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       is_lf;
      logic       is_cr;
      logic       read_ok;
      logic       col_zero;
      logic       col_last;
      logic       row_zero;
      logic       row_last;
      logic       idx_scroll_end;
      logic       idx_last;
      logic       cell_nonspace;
      logic       slot_free;
   } tcw_status_type;

endpackage

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: ties the controller to the datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_dp.
//
// A request transaction on req_* carries a put (character, line feed or carriage
// return), a backspace or a cell read. Each request produces exactly one response
// transaction on rsp_* with the cursor after it and, for in-range reads, the cell.
// The csr_* channel writes the foreground (index 0) and background (index 1) color
// nibbles used for newly written cells; it is always ready and should be used only
// while no request is in flight.
// Sequencing: a plain put, carriage return, read or line feed above the bottom row
// passes through ST_EXEC and ST_FINISH to the response register, and the next request
// can be taken in ST_FINISH if that register is free. A line feed or line wrap on the
// bottom row walks the whole screen RAM through one shared address: each cell is
// copied up from the row below (ST_SCR_RD, ST_SCR_WR), then the bottom row is blanked.
// A backspace at column 0 below the top row scans the row above from its end, one
// ST_SCAN_RD and ST_SCAN_CHK per cell. After reset the block clears the screen RAM
// one cell per cycle with req_ready low. A stalled receiver holds the response in its
// register; one more request is taken meanwhile and waits for the register to empty.
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  tcw_req_type          req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tcw_rsp_type          rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);

   tcw_cmd_type    cmd;
   tcw_status_type sts;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ----- design/tcw_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the screen cells; no package dependency.
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

endmodule

// ----- design/tcw_ctrl.sv -----
// Controller state machine: clearing pass, request sequencing, scroll and backspace scan.
// Depends on tcw_pkg for the state, command and status types.
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tcw_status_type sts,
   output tcw_cmd_type    cmd
);

   tcw_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.latch_req = 1'b0;
      cmd.hit_load  = 1'b0;
      cmd.mem_we    = 1'b0;
      cmd.mem_re    = 1'b0;
      cmd.addr_sel  = AD_CURSOR;
      cmd.wdata_sel = WD_SPACE;
      cmd.col_op    = COL_HOLD;
      cmd.row_op    = ROW_HOLD;
      cmd.idx_op    = IDX_HOLD;
      cmd.rsp_load  = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = AD_IDX;
            cmd.wdata_sel = WD_RESET;
            if (sts.idx_last) begin
               cmd.idx_op = IDX_ZERO;
               state_in   = ST_IDLE;
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end

         ST_EXEC: begin
            cmd.hit_load = 1'b1;
            state_in     = ST_FINISH;
            case (sts.req_type)
               REQ_PUT: begin
                  if (sts.is_lf) begin
                     if (sts.row_last) begin
                        cmd.idx_op = IDX_ZERO;
                        state_in   = ST_SCR_RD;
                     end else begin
                        cmd.row_op = ROW_INC;
                     end
                  end else if (sts.is_cr) begin
                     cmd.col_op = COL_ZERO;
                  end else begin
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = AD_CURSOR;
                     cmd.wdata_sel = WD_CHAR;
                     if (sts.col_last) begin
                        cmd.col_op = COL_ZERO;
                        if (sts.row_last) begin
                           cmd.idx_op = IDX_ZERO;
                           state_in   = ST_SCR_RD;
                        end else begin
                           cmd.row_op = ROW_INC;
                        end
                     end else begin
                        cmd.col_op = COL_INC;
                     end
                  end
               end
               REQ_BACKSPACE: begin
                  if (!sts.col_zero) begin
                     cmd.col_op    = COL_DEC;
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = AD_CURSOR_PREV;
                     cmd.wdata_sel = WD_SPACE;
                  end else if (!sts.row_zero) begin
                     // The scan walks the row above from its last column toward column 0.
                     cmd.row_op = ROW_DEC;
                     cmd.col_op = COL_LAST;
                     state_in   = ST_SCAN_RD;
                  end
               end
               REQ_READ: begin
                  if (sts.read_ok) begin
                     cmd.mem_re   = 1'b1;
                     cmd.addr_sel = AD_READ;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_SCR_RD: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = AD_IDX_NEXT_ROW;
            state_in     = ST_SCR_WR;
         end

         ST_SCR_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = AD_IDX;
            cmd.wdata_sel = WD_RDATA;
            if (sts.idx_scroll_end) begin
               cmd.idx_op = IDX_BLANK;
               state_in   = ST_BLANK;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = ST_SCR_RD;
            end
         end

         ST_BLANK: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = AD_IDX;
            cmd.wdata_sel = WD_SPACE;
            if (sts.idx_last) begin
               state_in = ST_FINISH;
            end else begin
               cmd.idx_op = IDX_INC;
            end
         end

         ST_SCAN_RD: begin
            cmd.mem_re   = 1'b1;
            cmd.addr_sel = AD_CURSOR;
            state_in     = ST_SCAN_CHK;
         end

         ST_SCAN_CHK: begin
            if (sts.cell_nonspace) begin
               cmd.col_op = COL_SCAN_END;
               state_in   = ST_FINISH;
            end else if (sts.col_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.col_op = COL_DEC;
               state_in   = ST_SCAN_RD;
            end
         end

         ST_FINISH: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.latch_req = 1'b1;
                  state_in      = ST_EXEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/tcw_dp.sv -----
// Datapath: request latch, cursor, sweep counter, color registers, screen RAM and
// the response register. Depends on tcw_pkg and tcw_ram.
module tcw_dp
   import tcw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  tcw_req_type          req_payload,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output tcw_rsp_type          rsp_payload,
   input  tcw_cmd_type          cmd,
   output tcw_status_type       sts
);

   tcw_req_type        req_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [COLOR_W-1:0] fg_ff, bg_ff;
   logic               hit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tcw_rsp_type        rsp_ff;

   logic [ADDR_W-1:0]  cursor_addr;
   logic [ADDR_W-1:0]  read_addr;
   logic [ADDR_W-1:0]  mem_addr;
   logic [CELL_W-1:0]  mem_wdata;
   logic [CELL_W-1:0]  mem_rdata;
   logic               read_ok;

   assign cursor_addr = ADDR_W'(col_ff) + ADDR_W'(row_ff) * ADDR_W'(COLS);
   assign read_addr   = ADDR_W'(req_ff.read_col) + ADDR_W'(req_ff.read_row) * ADDR_W'(COLS);
   assign read_ok     = (int'(req_ff.read_col) < COLS) && (int'(req_ff.read_row) < ROWS);

   always_comb begin
      case (cmd.addr_sel)
         AD_CURSOR:       mem_addr = cursor_addr;
         AD_CURSOR_PREV:  mem_addr = cursor_addr - 1'b1;
         AD_IDX:          mem_addr = idx_ff;
         AD_IDX_NEXT_ROW: mem_addr = idx_ff + ADDR_W'(COLS);
         AD_READ:         mem_addr = read_addr;
         default:         mem_addr = cursor_addr;
      endcase

      case (cmd.wdata_sel)
         WD_RESET: mem_wdata = {RESET_ATTR, CH_SPACE};
         WD_CHAR:  mem_wdata = {bg_ff, fg_ff, req_ff.char_code};
         WD_SPACE: mem_wdata = {bg_ff, fg_ff, CH_SPACE};
         WD_RDATA: mem_wdata = mem_rdata;
         default:  mem_wdata = {bg_ff, fg_ff, CH_SPACE};
      endcase
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (NCELLS)
   ) u_ram (
      .clock    (clock),
      .we       (cmd.mem_we),
      .waddr    (mem_addr),
      .wdata    (mem_wdata),
      .re       (cmd.mem_re),
      .raddr    (mem_addr),
      .rdata_ff (mem_rdata)
   );

   always_comb begin
      case (cmd.col_op)
         COL_ZERO:     col_in = '0;
         COL_INC:      col_in = col_ff + 1'b1;
         COL_DEC:      col_in = col_ff - 1'b1;
         COL_LAST:     col_in = COL_W'(COLS - 1);
         // One past the last visible character, held at the last column.
         COL_SCAN_END: col_in = sts.col_last ? col_ff : col_ff + 1'b1;
         default:      col_in = col_ff;
      endcase

      case (cmd.row_op)
         ROW_INC: row_in = row_ff + 1'b1;
         ROW_DEC: row_in = row_ff - 1'b1;
         default: row_in = row_ff;
      endcase

      case (cmd.idx_op)
         IDX_ZERO:  idx_in = '0;
         IDX_INC:   idx_in = idx_ff + 1'b1;
         IDX_BLANK: idx_in = ADDR_W'(NCELLS - COLS);
         default:   idx_in = idx_ff;
      endcase

      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ff       <= '0;
         fg_ff        <= RESET_FG;
         bg_ff        <= RESET_BG;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && (csr_index == CSR_FG_COLOR)) begin
            fg_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_BG_COLOR)) begin
            bg_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff <= req_payload;
      end
      if (cmd.hit_load) begin
         hit_ff <= (req_ff.req_type == REQ_READ) && read_ok;
      end
      if (cmd.rsp_load) begin
         rsp_ff.cursor_col    <= 7'(col_ff);
         rsp_ff.cursor_row    <= 5'(row_ff);
         rsp_ff.cursor_offset <= 11'(cursor_addr);
         rsp_ff.cell_char     <= hit_ff ? mem_rdata[7:0] : 8'd0;
         rsp_ff.cell_attr     <= hit_ff ? mem_rdata[15:8] : 8'd0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.req_type       = req_ff.req_type;
   assign sts.is_lf          = (req_ff.char_code == CH_LF);
   assign sts.is_cr          = (req_ff.char_code == CH_CR);
   assign sts.read_ok        = read_ok;
   assign sts.col_zero       = (col_ff == '0);
   assign sts.col_last       = (col_ff == COL_W'(COLS - 1));
   assign sts.row_zero       = (row_ff == '0);
   assign sts.row_last       = (row_ff == ROW_W'(ROWS - 1));
   assign sts.idx_scroll_end = (idx_ff == ADDR_W'(NCELLS - COLS - 1));
   assign sts.idx_last       = (idx_ff == ADDR_W'(NCELLS - 1));
   assign sts.cell_nonspace  = (mem_rdata[7:0] != CH_SPACE);
   assign sts.slot_free      = !rsp_valid_ff || rsp_ready;

endmodule

// ----- design/tcw_checker.sv -----
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer.
module tcw_checker
   import tcw_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input tcw_rsp_type rsp_payload
);

   // The clearing pass keeps requests out and the response register empty.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request or response active right after reset");

   // An accepted request is executed before the next one can be taken.
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted in the cycle right after an acceptance");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response valid dropped before acceptance");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload))
      else $error("response payload changed while stalled");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- sim/tb.sv -----
// Self-checking testbench for text_console_writer: random and directed console traffic.
// Depends on tcw_pkg and the text_console_writer RTL; holds its own console predictor.
module tb;
   import tcw_pkg::*;

   localparam int RUN_LIMIT   = 8000000;
   localparam int SETTLE      = 8;
   localparam int PHASE_ITEMS = 145;

   localparam logic [1:0]           REQ_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3  = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   tcw_req_type          req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   tcw_rsp_type          rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]   csr_data = '0;

   text_console_writer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // Console predictor state.
   logic [15:0]        screen_model [NCELLS];
   int unsigned        col_m;
   int unsigned        row_m;
   logic [COLOR_W-1:0] fg_m;
   logic [COLOR_W-1:0] bg_m;

   tcw_req_type request_q [$];
   tcw_rsp_type cursor_reports_q [$];

   int unsigned queued_cnt;
   int unsigned checked_cnt;
   int unsigned err_cnt;
   int unsigned cycle_cnt;
   int unsigned put_cnt, bs_cnt, read_cnt, scroll_cnt, climb_cnt, last_col_cnt;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;

   function automatic logic [15:0] colored_cell(input logic [7:0] ch);
      return {bg_m, fg_m, ch};
   endfunction

   function automatic void reset_console_model();
      int i;
      fg_m  = RESET_FG;
      bg_m  = RESET_BG;
      col_m = 0;
      row_m = 0;
      for (i = 0; i < NCELLS; i++)
         screen_model[i] = colored_cell(CH_SPACE);
   endfunction

   function automatic void move_down_line();
      int i;
      if (row_m + 1 < ROWS) begin
         row_m++;
         return;
      end
      scroll_cnt++;
      for (i = 0; i < NCELLS - COLS; i++)
         screen_model[i] = screen_model[i + COLS];
      for (i = 0; i < COLS; i++)
         screen_model[i + COLS * (ROWS - 1)] = colored_cell(CH_SPACE);
   endfunction

   function automatic tcw_rsp_type apply_request(input tcw_req_type rq);
      tcw_rsp_type rsp;
      int unsigned c;
      int unsigned off;
      bit          found;
      logic [15:0] cell_word;
      rsp = '0;
      case (rq.req_type)
         REQ_PUT: begin
            put_cnt++;
            if (rq.char_code == CH_LF) begin
               move_down_line();
            end else if (rq.char_code == CH_CR) begin
               col_m = 0;
            end else begin
               screen_model[col_m + COLS * row_m] = colored_cell(rq.char_code);
               col_m++;
               if (col_m >= COLS) begin
                  move_down_line();
                  col_m = 0;
               end
            end
         end
         REQ_BACKSPACE: begin
            bs_cnt++;
            if (col_m > 0) begin
               col_m--;
               screen_model[col_m + COLS * row_m] = colored_cell(CH_SPACE);
            end else if (row_m > 0) begin
               // Land one past the last non-space cell of the row above, held at the last column.
               climb_cnt++;
               row_m--;
               col_m = 0;
               found = 1'b0;
               for (c = COLS; c > 0 && !found; c--) begin
                  if (screen_model[c - 1 + COLS * row_m][7:0] != CH_SPACE) begin
                     found = 1'b1;
                     col_m = (c > COLS - 1) ? COLS - 1 : c;
                  end
               end
               if (col_m == COLS - 1)
                  last_col_cnt++;
            end
         end
         REQ_READ: begin
            read_cnt++;
            if (rq.read_col < COLS && rq.read_row < ROWS) begin
               cell_word = screen_model[rq.read_col + COLS * rq.read_row];
               rsp.cell_char = cell_word[7:0];
               rsp.cell_attr = cell_word[15:8];
            end
         end
         default: ;
      endcase
      off = col_m + COLS * row_m;
      rsp.cursor_col    = col_m[6:0];
      rsp.cursor_row    = row_m[4:0];
      rsp.cursor_offset = off[10:0];
      return rsp;
   endfunction

   // Request driver: the prediction is made when the transaction is accepted.
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            cursor_reports_q.push_back(apply_request(req_payload));
         if (!req_valid || req_ready) begin
            if (request_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_payload <= request_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic bit field_ok(input string name, input int unsigned want,
                                   input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin : rsp_monitor
      tcw_rsp_type want;
      bit          ok;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (cursor_reports_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual %h", $time, rsp_payload);
               err_cnt++;
            end else begin
               want = cursor_reports_q.pop_front();
               ok = field_ok("cursor_col", 32'(want.cursor_col),
                             32'(rsp_payload.cursor_col))
                  & field_ok("cursor_row", 32'(want.cursor_row),
                             32'(rsp_payload.cursor_row))
                  & field_ok("cursor_offset", 32'(want.cursor_offset),
                             32'(rsp_payload.cursor_offset))
                  & field_ok("cell_char", 32'(want.cell_char),
                             32'(rsp_payload.cell_char))
                  & field_ok("cell_attr", 32'(want.cell_attr),
                             32'(rsp_payload.cell_attr));
               if (!ok)
                  err_cnt++;
               checked_cnt++;
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= RUN_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic push_req(input logic [1:0] kind, input logic [7:0] ch);
      tcw_req_type rq;
      rq.req_type  = kind;
      rq.char_code = ch;
      rq.read_col  = 7'($urandom_range(127, 0));
      rq.read_row  = 5'($urandom_range(31, 0));
      request_q.push_back(rq);
      queued_cnt++;
   endtask

   task automatic push_read_at(input logic [6:0] col, input logic [4:0] row);
      tcw_req_type rq;
      rq.req_type  = REQ_READ;
      rq.char_code = 8'($urandom_range(255, 0));
      rq.read_col  = col;
      rq.read_row  = row;
      request_q.push_back(rq);
      queued_cnt++;
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] ch;
      if ($urandom_range(5, 0) == 0)
         return CH_SPACE;
      do
         ch = 8'($urandom_range(255, 0));
      while (ch == CH_LF || ch == CH_CR);
      return ch;
   endfunction

   // One burst: a run of line feeds, or text then line endings, edits, reads or random requests.
   task automatic gen_burst();
      int unsigned pick;
      int unsigned run_len;
      int unsigned n;
      pick = $urandom_range(99, 0);
      if (pick < 3) begin
         run_len = $urandom_range(26, 8);
         for (n = 0; n < run_len; n++)
            push_req(REQ_PUT, CH_LF);
         return;
      end
      run_len = (pick < 11) ? $urandom_range(90, 70) : $urandom_range(8, 0);
      for (n = 0; n < run_len; n++)
         push_req(REQ_PUT, text_byte());
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
         push_req(REQ_PUT, CH_CR);
         repeat ($urandom_range(3, 1)) push_req(REQ_PUT, CH_LF);
      end else if (pick < 55) begin
         push_req(REQ_PUT, CH_LF);
      end else if (pick < 62) begin
         push_req(REQ_PUT, CH_CR);
      end else if (pick < 80) begin
         repeat ($urandom_range(6, 1)) push_req(REQ_BACKSPACE, text_byte());
      end else if (pick < 92) begin
         repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(5, 0) == 0)
               push_read_at(7'($urandom_range(127, 0)), 5'($urandom_range(31, 0)));
            else
               push_read_at(7'($urandom_range(COLS - 1, 0)),
                            5'($urandom_range(ROWS - 1, 0)));
         end
      end else begin
         repeat ($urandom_range(3, 1))
            push_req(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
      end
   endtask

   task automatic wait_drained();
      while (request_q.size() != 0 || req_valid || cursor_reports_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic program_color(input logic [CSR_IDX_W-1:0] idx,
                                input logic [COLOR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         CSR_FG_COLOR: fg_m = val;
         CSR_BG_COLOR: bg_m = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned target;
      int          phase;
      reset_console_model();
      send_idle_pct = 0;
      recv_idle_pct = 0;

      // Directed opening with the reset colors.
      push_read_at(7'd0, 5'd0);
      push_read_at(7'(COLS - 1), 5'(ROWS - 1));
      push_read_at(7'(COLS), 5'd0);
      push_read_at(7'd0, 5'(ROWS));
      push_read_at(7'd127, 5'd31);
      push_req(REQ_UNUSED, 8'hFF);
      push_req(REQ_BACKSPACE, 8'h00);
      push_req(REQ_PUT, 8'h41);
      push_req(REQ_PUT, 8'hFF);
      push_req(REQ_PUT, 8'h00);
      push_req(REQ_PUT, CH_SPACE);
      push_req(REQ_PUT, CH_CR);
      push_read_at(7'd0, 5'd0);
      push_req(REQ_PUT, CH_LF);
      push_req(REQ_BACKSPACE, 8'h00);
      push_req(REQ_BACKSPACE, 8'hFF);
      push_read_at(7'd2, 5'd0);
      push_req(REQ_PUT, CH_CR);
      push_req(REQ_PUT, CH_LF);
      push_req(REQ_PUT, CH_LF);
      push_req(REQ_BACKSPACE, 8'h00);
      push_req(REQ_PUT, 8'h7F);
      push_read_at(7'd0, 5'd1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < 3; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 60;
               program_color(CSR_FG_COLOR, 4'h0);
               program_color(CSR_BG_COLOR, 4'hF);
               program_color(CSR_SPARE_2, 4'h5);
            end
            1: begin
               send_idle_pct = 60;
               recv_idle_pct = 29;
               program_color(CSR_FG_COLOR, 4'hF);
               program_color(CSR_BG_COLOR, 4'h0);
               program_color(CSR_SPARE_3, 4'hA);
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               program_color(CSR_FG_COLOR, 4'($urandom_range(15, 0)));
               program_color(CSR_BG_COLOR, 4'($urandom_range(15, 0)));
            end
         endcase
         @(negedge clock);
         target = queued_cnt + PHASE_ITEMS / 2;
         while (queued_cnt < target)
            gen_burst();
         // Hold the sender until every outstanding response is back.
         wait_drained();
         target = queued_cnt + PHASE_ITEMS - PHASE_ITEMS / 2;
         while (queued_cnt < target)
            gen_burst();
      end

      wait_drained();
      $display("Checked %0d responses: %0d puts, %0d backspaces, %0d reads, %0d scrolls.",
               checked_cnt, put_cnt, bs_cnt, read_cnt, scroll_cnt);
      $display("Backspace climbed a row %0d times, landing on the last column %0d times.",
               climb_cnt, last_col_cnt);
      if (err_cnt == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
